/* hw/rtl/trf_pkg.sv */
`timescale 1ns / 1ps

package trf_pkg;

  localparam int unsigned MAX_ROUTING_BYTES = 11;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        CFG_IDX_ROUTING_LEN = 1'b0;
  localparam logic [3:0]  ROUTING_LEN_RESET = 4'd9;

  localparam logic [7:0] HDR_LEAD     = 8'h00;
  localparam logic [7:0] HDR_IDENTITY = 8'h05;
  localparam logic [7:0] HDR_ROUTING  = 8'h08;
  localparam logic [7:0] HDR_BATTERY  = 8'h01;
  localparam logic [7:0] SIG_MASK     = 8'hE0;
  localparam logic [7:0] SIG_SHORT    = 8'h60;
  localparam logic [7:0] SIG_LONG     = 8'h40;

  localparam logic [8:0] IDENTITY_LEN  = 9'd12;
  localparam logic [8:0] ROUTING_SKIP  = 9'd7;
  localparam logic [2:0] SHORT_KEY_LEN = 3'd2;
  localparam logic [2:0] LONG_KEY_LEN  = 3'd6;

  typedef enum logic [2:0] {
    FR_IDLE     = 3'd0,
    FR_HEADER   = 3'd1,
    FR_IDENTITY = 3'd2,
    FR_ROUTING  = 3'd3,
    FR_KEYS     = 3'd4
  } frame_t;

  typedef enum logic [2:0] {
    KIND_KEYS        = 3'd0,
    KIND_ROUTING     = 3'd1,
    KIND_BATTERY     = 3'd2,
    KIND_IDENTITY    = 3'd3,
    KIND_INVALID     = 3'd4,
    KIND_LENGTH_ERR  = 3'd5
  } kind_t;

  function automatic logic [7:0] key_sig(input logic long_layout, input logic [2:0] slot);
    logic [7:0] sig;
    sig = 8'hE0;
    if (long_layout) begin
      case (slot)
        3'd0: sig = 8'h40;
        3'd1: sig = 8'hC0;
        3'd2: sig = 8'h20;
        3'd3: sig = 8'hA0;
        3'd4: sig = 8'h60;
        default: sig = 8'hE0;
      endcase
    end else begin
      sig = (slot == 3'd0) ? 8'h60 : 8'hE0;
    end
    return sig;
  endfunction

  function automatic logic [7:0] key_mask(input logic long_layout, input logic [2:0] slot);
    logic [7:0] msk;
    msk = 8'h1F;
    if (long_layout) begin
      case (slot)
        3'd0, 3'd1: msk = 8'h0F;
        3'd2, 3'd3: msk = 8'h05;
        default:    msk = 8'h1F;
      endcase
    end
    return msk;
  endfunction

  function automatic logic [4:0] key_shift(input logic long_layout, input logic [2:0] slot);
    logic [4:0] sh;
    sh = 5'd5;
    if (long_layout) begin
      case (slot)
        3'd0: sh = 5'd10;
        3'd1: sh = 5'd14;
        3'd2: sh = 5'd18;
        3'd3: sh = 5'd21;
        3'd4: sh = 5'd24;
        default: sh = 5'd5;
      endcase
    end else begin
      sh = (slot == 3'd0) ? 5'd0 : 5'd5;
    end
    return sh;
  endfunction

endpackage

/* hw/rtl/trf_if.sv */
`timescale 1ns / 1ps

interface trf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface trf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [28:0] key_set;
  logic [7:0]  column_count;
  logic [7:0]  dot_count;
  logic [3:0]  routing_slot;
  logic [7:0]  routing_bits;
  logic        final_item;

  modport source (output valid, output kind, output key_set, output column_count,
                  output dot_count, output routing_slot, output routing_bits,
                  output final_item, input ready);
  modport sink (input valid, input kind, input key_set, input column_count,
                input dot_count, input routing_slot, input routing_bits,
                input final_item, output ready);
endinterface

/* hw/rtl/terminal_reply_framer.sv */
`timescale 1ns / 1ps
// channel   dir  handshake             payload
// in_ch     in   valid/ready           rx_byte
// out_ch    out  valid/ready           kind, key_set, column_count, dot_count,
//                                      routing_slot, routing_bits, final_item
// cfg       in   psel/penable/pwrite   paddr, pwdata, prdata (routing_report_length)
//
// One byte per cycle while in_ch.ready is high; the framing state updates at the accepting edge.
// A result beat appears in the cycle after its byte is accepted, from the output register.
// in_ch.ready is high whenever the output register is empty or being drained.
// Synchronous active-low reset returns framing to idle and length to 9.

module terminal_reply_framer (
  input  logic                             clk,
  input  logic                             rst_n,
  trf_in_if.sink                           in_ch,
  trf_out_if.source                        out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [trf_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [trf_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [trf_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  logic [3:0]      routing_len_r;

  trf_pkg::frame_t frame_r, frame_nxt;
  logic [8:0]      pos_r, pos_nxt;
  logic [8:0]      exp_len_r, exp_len_nxt;
  logic            long_keys_r, long_keys_nxt;
  logic [28:0]     key_acc_r, key_acc_nxt;
  logic [7:0]      column_hold_r, column_hold_nxt;
  logic            mismatch_r, mismatch_nxt;

  logic            out_valid_r, out_valid_nxt;
  trf_pkg::kind_t  kind_r, kind_nxt;
  logic [28:0]     key_set_r, key_set_nxt;
  logic [7:0]      column_count_r, column_count_nxt;
  logic [7:0]      dot_count_r, dot_count_nxt;
  logic [3:0]      routing_slot_r, routing_slot_nxt;
  logic [7:0]      routing_bits_r, routing_bits_nxt;
  logic            final_item_r, final_item_nxt;

  logic            accept;
  logic            emit;
  logic [7:0]      b;
  logic [8:0]      pos_inc;
  logic            routing_in_range;
  logic [2:0]      key_count;
  logic [2:0]      key_slot;
  logic [7:0]      sig;
  logic [7:0]      msk;
  logic [4:0]      sh;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == trf_pkg::CFG_IDX_ROUTING_LEN)
                  ? {{(trf_pkg::CFG_DATA_W-4){1'b0}}, routing_len_r}
                  : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      routing_len_r <= trf_pkg::ROUTING_LEN_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == trf_pkg::CFG_IDX_ROUTING_LEN) begin
      routing_len_r <= pwdata[3:0];
    end
  end

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign pos_inc     = pos_r + 9'd1;
  assign routing_in_range = (pos_r >= trf_pkg::ROUTING_SKIP)
      && ((pos_r - trf_pkg::ROUTING_SKIP) < 9'(trf_pkg::MAX_ROUTING_BYTES));
  assign key_count = long_keys_r ? trf_pkg::LONG_KEY_LEN : trf_pkg::SHORT_KEY_LEN;
  assign key_slot  = (pos_r < {6'd0, key_count}) ? pos_r[2:0] : key_count - 3'd1;
  assign sig       = trf_pkg::key_sig(long_keys_r, key_slot);
  assign msk       = trf_pkg::key_mask(long_keys_r, key_slot);
  assign sh        = trf_pkg::key_shift(long_keys_r, key_slot);

  always_comb begin
    frame_nxt        = frame_r;
    pos_nxt          = pos_r;
    exp_len_nxt      = exp_len_r;
    long_keys_nxt    = long_keys_r;
    key_acc_nxt      = key_acc_r;
    column_hold_nxt  = column_hold_r;
    mismatch_nxt     = mismatch_r;
    emit             = 1'b0;
    kind_nxt         = trf_pkg::KIND_INVALID;
    key_set_nxt      = '0;
    column_count_nxt = '0;
    dot_count_nxt    = '0;
    routing_slot_nxt = '0;
    routing_bits_nxt = '0;
    final_item_nxt   = 1'b0;

    if (accept) begin
      case (frame_r)
        trf_pkg::FR_HEADER: begin
          if (b == trf_pkg::HDR_IDENTITY) begin
            frame_nxt   = trf_pkg::FR_IDENTITY;
            pos_nxt     = 9'd2;
            exp_len_nxt = trf_pkg::IDENTITY_LEN;
          end else if (b == trf_pkg::HDR_ROUTING) begin
            frame_nxt   = trf_pkg::FR_ROUTING;
            pos_nxt     = 9'd2;
            exp_len_nxt = 9'd3;
          end else begin
            frame_nxt    = trf_pkg::FR_IDLE;
            pos_nxt      = '0;
            exp_len_nxt  = '0;
            mismatch_nxt = 1'b0;
            emit         = 1'b1;
            kind_nxt     = (b == trf_pkg::HDR_BATTERY) ? trf_pkg::KIND_BATTERY
                                                       : trf_pkg::KIND_INVALID;
          end
        end

        trf_pkg::FR_IDENTITY: begin
          if (pos_r == 9'd2) begin
            column_hold_nxt = b;
          end else if (pos_r == 9'd3) begin
            key_acc_nxt = {21'd0, b};
          end
          pos_nxt = pos_inc;
          if (pos_inc >= exp_len_r) begin
            frame_nxt        = trf_pkg::FR_IDLE;
            pos_nxt          = '0;
            exp_len_nxt      = '0;
            mismatch_nxt     = 1'b0;
            emit             = 1'b1;
            kind_nxt         = trf_pkg::KIND_IDENTITY;
            column_count_nxt = column_hold_nxt;
            dot_count_nxt    = key_acc_nxt[7:0];
          end
        end

        trf_pkg::FR_ROUTING: begin
          if (pos_r == 9'd2) begin
            exp_len_nxt  = 9'd3 + {1'b0, b};
            mismatch_nxt = (b != {4'd0, routing_len_r});
            pos_nxt      = 9'd3;
            if (b == 8'd0) begin
              frame_nxt    = trf_pkg::FR_IDLE;
              pos_nxt      = '0;
              exp_len_nxt  = '0;
              mismatch_nxt = 1'b0;
              emit         = (b != {4'd0, routing_len_r});
              kind_nxt     = trf_pkg::KIND_LENGTH_ERR;
            end
          end else begin
            pos_nxt = pos_inc;
            if (pos_inc >= exp_len_r) begin
              frame_nxt    = trf_pkg::FR_IDLE;
              pos_nxt      = '0;
              exp_len_nxt  = '0;
              mismatch_nxt = 1'b0;
              if (mismatch_r) begin
                emit     = 1'b1;
                kind_nxt = trf_pkg::KIND_LENGTH_ERR;
              end else if (routing_in_range) begin
                emit             = 1'b1;
                kind_nxt         = trf_pkg::KIND_ROUTING;
                routing_slot_nxt = 4'(pos_r - trf_pkg::ROUTING_SKIP);
                routing_bits_nxt = b;
                final_item_nxt   = 1'b1;
              end
            end else if (!mismatch_r && routing_in_range) begin
              emit             = 1'b1;
              kind_nxt         = trf_pkg::KIND_ROUTING;
              routing_slot_nxt = 4'(pos_r - trf_pkg::ROUTING_SKIP);
              routing_bits_nxt = b;
            end
          end
        end

        trf_pkg::FR_KEYS: begin
          if ((b & trf_pkg::SIG_MASK) != sig) begin
            frame_nxt    = trf_pkg::FR_IDLE;
            pos_nxt      = '0;
            exp_len_nxt  = '0;
            mismatch_nxt = 1'b0;
            emit         = 1'b1;
            kind_nxt     = trf_pkg::KIND_INVALID;
          end else begin
            key_acc_nxt = key_acc_r | (29'(b & msk) << sh);
            pos_nxt     = {6'd0, key_slot + 3'd1};
            if ((key_slot + 3'd1) >= key_count) begin
              frame_nxt    = trf_pkg::FR_IDLE;
              pos_nxt      = '0;
              exp_len_nxt  = '0;
              mismatch_nxt = 1'b0;
              emit         = 1'b1;
              kind_nxt     = trf_pkg::KIND_KEYS;
              key_set_nxt  = key_acc_nxt;
            end
          end
        end

        default: begin
          frame_nxt    = trf_pkg::FR_IDLE;
          pos_nxt      = '0;
          exp_len_nxt  = '0;
          mismatch_nxt = 1'b0;
          if (b == trf_pkg::HDR_LEAD) begin
            frame_nxt   = trf_pkg::FR_HEADER;
            pos_nxt     = 9'd1;
            exp_len_nxt = 9'd2;
          end else if ((b & trf_pkg::SIG_MASK) == trf_pkg::SIG_SHORT) begin
            frame_nxt     = trf_pkg::FR_KEYS;
            long_keys_nxt = 1'b0;
            key_acc_nxt   = {24'd0, b[4:0]};
            pos_nxt       = 9'd1;
            exp_len_nxt   = 9'd2;
          end else if ((b & trf_pkg::SIG_MASK) == trf_pkg::SIG_LONG) begin
            frame_nxt     = trf_pkg::FR_KEYS;
            long_keys_nxt = 1'b1;
            key_acc_nxt   = {15'd0, b[3:0], 10'd0};
            pos_nxt       = 9'd1;
            exp_len_nxt   = 9'd6;
          end else begin
            emit     = 1'b1;
            kind_nxt = trf_pkg::KIND_INVALID;
          end
        end
      endcase
    end
  end

  assign out_valid_nxt = accept ? emit : (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r       <= trf_pkg::FR_IDLE;
      pos_r         <= '0;
      exp_len_r     <= '0;
      long_keys_r   <= 1'b0;
      key_acc_r     <= '0;
      column_hold_r <= '0;
      mismatch_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      frame_r       <= frame_nxt;
      pos_r         <= pos_nxt;
      exp_len_r     <= exp_len_nxt;
      long_keys_r   <= long_keys_nxt;
      key_acc_r     <= key_acc_nxt;
      column_hold_r <= column_hold_nxt;
      mismatch_r    <= mismatch_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      kind_r         <= kind_nxt;
      key_set_r      <= key_set_nxt;
      column_count_r <= column_count_nxt;
      dot_count_r    <= dot_count_nxt;
      routing_slot_r <= routing_slot_nxt;
      routing_bits_r <= routing_bits_nxt;
      final_item_r   <= final_item_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.key_set      = key_set_r;
  assign out_ch.column_count = column_count_r;
  assign out_ch.dot_count    = dot_count_r;
  assign out_ch.routing_slot = routing_slot_r;
  assign out_ch.routing_bits = routing_bits_r;
  assign out_ch.final_item   = final_item_r;

  a_idle_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    frame_r == trf_pkg::FR_IDLE |-> (pos_r == 9'd0 && !mismatch_r))
    else $error("idle framer holds a stale position or mismatch flag");

  a_keys_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    frame_r == trf_pkg::FR_KEYS |-> (pos_r != 9'd0 && pos_r < {6'd0, key_count}))
    else $error("key report position outside its layout");

  a_routing_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == trf_pkg::KIND_ROUTING)
      |-> ({1'b0, routing_slot_r} < 5'(trf_pkg::MAX_ROUTING_BYTES)))
    else $error("routing beat carries a slot past the last key byte");

  a_lead_opens_header: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && frame_r == trf_pkg::FR_IDLE && b == trf_pkg::HDR_LEAD)
      |=> (frame_r == trf_pkg::FR_HEADER && !out_valid_r))
    else $error("lead byte did not open a header without a result");

endmodule
